[hdl/mlcd_pkg.sv]
// shared types, constants and lookup tables of the logit density block
`default_nettype none
package mlcd_pkg;

    localparam int DEF_MAX_TERMS      = 16;
    localparam int DEF_MAX_CATEGORIES = 8;
    localparam int VAL_W              = 24;
    localparam int LP_W               = 40;
    localparam int Q_ONE              = 65536;
    localparam int LN2_Q16            = 45426;
    localparam int DIV_NW             = 34;

    typedef enum logic [1:0] {
        REG_FEATURE_COUNT  = 2'd0,
        REG_CATEGORY_COUNT = 2'd1,
        REG_LOG_OUTPUT     = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SLOT, S_IWT, S_CRD, S_CWT, S_ADD, S_NXT, S_FIN, S_MAX,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_RES, S_DGO, S_DWT, S_L1, S_L2, S_L3
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [16:0] exp_int_lut(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_frac_lut(input logic [2:0] j);
        logic [16:0] v;
        case (j)
            3'd0:    v = 17'd65536;
            3'd1:    v = 17'd57835;
            3'd2:    v = 17'd51039;
            3'd3:    v = 17'd45042;
            3'd4:    v = 17'd39750;
            3'd5:    v = 17'd35079;
            3'd6:    v = 17'd30957;
            3'd7:    v = 17'd27319;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] ln_lut(input logic [2:0] j);
        logic [15:0] v;
        case (j)
            3'd0:    v = 16'd0;
            3'd1:    v = 16'd7719;
            3'd2:    v = 16'd14624;
            3'd3:    v = 16'd20870;
            3'd4:    v = 16'd26573;
            3'd5:    v = 16'd31818;
            3'd6:    v = 16'd36675;
            3'd7:    v = 16'd41196;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/multinomial_logit_category_density.sv]
// top level: coefficient store, predictor accumulation and softmax output
//
// A coefficient load (mode 0) is written to the coefficient ram in the cycle
// it is accepted and busy stays low, so loads go one per cycle while no
// covariate beat is in flight. A covariate beat walks the category columns
// one at a time through the ram read port and a single 24x24 multiplier. The
// last covariate then adds the maximum search, the exp of each category and
// a serial divide, plus the ln steps in log mode.
// The single result appears on density/category_error for one cycle with done
// high; there is no back-pressure, the receiver must take it then.
`default_nettype none
module multinomial_logit_category_density import mlcd_pkg::*; #(
    parameter int MAX_TERMS      = DEF_MAX_TERMS,
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [3:0]        term_index,
    input  wire logic [2:0]        category_slot,
    input  wire logic signed [23:0] value,
    input  wire logic [3:0]        observed_category,
    input  wire logic              last_feature,
    output logic                   done,
    output logic signed [23:0]     density,
    output logic                   category_error,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    localparam int NSLOT = MAX_CATEGORIES - 1;
    localparam int DEPTH = MAX_TERMS * NSLOT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int KW    = $clog2(MAX_CATEGORIES + 1);
    localparam int SUMW  = $clog2(MAX_CATEGORIES * Q_ONE + 1);
    localparam int KSW   = $clog2(SUMW);

    state_t state_reg, state_next;

    logic [3:0] fc_reg, cc_reg;
    logic       log_reg;
    logic [3:0] pos_reg;
    logic       done_reg;
    logic       cfg_we;
    reg_idx_t   cfg_idx;

    logic              accept, ld_ok;
    logic [AW-1:0]     ld_addr, ram_raddr, coef_addr;
    logic [VAL_W-1:0]  ram_rdata;

    logic signed [VAL_W-1:0] val_reg;
    logic [3:0]        obs_reg;
    logic              last_reg, first_reg, apply_reg;
    logic [IW-1:0]     slot_reg;
    logic [KW-1:0]     k_reg, keff_reg, km1;
    logic [IW-1:0]     lp_idx;
    logic signed [LP_W-1:0] lp_reg [NSLOT];
    logic signed [LP_W-1:0] lp_rd, m_reg, eta;
    logic signed [47:0] prod_reg;
    logic signed [31:0] prod_sh;
    logic signed [LP_W:0] acc;
    logic [LP_W-1:0]   acc_sat;

    logic [LP_W:0]     n_reg;
    logic signed [LP_W:0] deta_reg, d_obs_reg;
    logic              zero_reg;
    logic [12:0]       r_reg;
    logic [9:0]        r2_reg;
    logic [6:0]        r3_reg;
    logic [32:0]       eif_reg;
    logic [16:0]       e1_reg, poly_reg, e_obs_reg, e_cur;
    logic [34:0]       e_prod;
    logic [SUMW-1:0]   sum_reg;
    logic              bad_obs;
    logic [3:0]        obs_m1;

    logic [KSW-1:0]    ks, ks_reg;
    logic [2:0]        j_reg;
    logic [DIV_NW-1:0] div_num_reg, div_quot;
    logic [SUMW-1:0]   div_den_reg;
    logic              div_start;
    div_stat_t         div_stat;
    logic [12:0]       t_reg;
    logic [9:0]        t2_reg;
    logic [6:0]        t3_reg;
    logic [19:0]       ln_val;
    logic signed [LP_W+1:0] lres;
    logic signed [23:0] lres_sat;
    logic signed [23:0] density_reg;
    logic              cat_err_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_FEATURE_COUNT:  prdata = {28'd0, fc_reg};
            REG_CATEGORY_COUNT: prdata = {28'd0, cc_reg};
            REG_LOG_OUTPUT:     prdata = {31'd0, log_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign accept    = start && !busy;
    assign ld_ok     = (int'(term_index) < MAX_TERMS) && (int'(category_slot) < NSLOT);
    assign ld_addr   = AW'(int'(term_index) * NSLOT + int'(category_slot));
    assign coef_addr = AW'((int'(pos_reg) + 1) * NSLOT + int'(slot_reg));

    mlcd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (accept && !mode && ld_ok),
        .waddr (ld_addr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // predictor register file, one read index
    assign km1    = k_reg - KW'(1);
    assign lp_idx = (state_reg == S_MAX || state_reg == S_E0) ? km1[IW-1:0] : slot_reg;
    assign lp_rd  = (int'(lp_idx) < NSLOT) ? lp_reg[lp_idx] : '0;
    assign eta    = (k_reg == '0) ? '0 : lp_rd;

    assign prod_sh = prod_reg[47:16];
    assign acc     = {lp_rd[LP_W-1], lp_rd} + {{(LP_W-31){prod_sh[31]}}, prod_sh};
    always_comb
    begin
        if (acc[LP_W] != acc[LP_W-1])
        begin
            acc_sat = acc[LP_W] ? {1'b1, {(LP_W-1){1'b0}}} : {1'b0, {(LP_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc[LP_W-1:0];
        end
    end

    assign obs_m1  = obs_reg - 4'd1;
    assign bad_obs = (obs_reg == 4'd0) || (int'(obs_reg) > int'(keff_reg));

    assign e_prod = {1'b0, e1_reg} * {1'b0, poly_reg} + 35'd32768;
    assign e_cur  = zero_reg ? 17'd0 : e_prod[32:16];

    // normalize sum into [1,2)
    always_comb
    begin
        ks = '0;
        for (int b = 17; b < SUMW; b++)
        begin
            if (sum_reg[b])
            begin
                ks = KSW'(b - 16);
            end
        end
    end

    assign ln_val = 20'(ks_reg * LN2_Q16) + {4'd0, ln_lut(j_reg)} + {7'd0, t_reg}
                  - {11'd0, t2_reg[9:1]} + 20'(({17'd0, t3_reg} * 24'd43691) >> 17);
    assign lres   = {d_obs_reg[LP_W], d_obs_reg} - {{(LP_W-18){1'b0}}, ln_val};
    always_comb
    begin
        if (lres < -42'sd8388608)
        begin
            lres_sat = 24'sh800000;
        end
        else if (lres > 42'sd8388607)
        begin
            lres_sat = 24'sh7FFFFF;
        end
        else
        begin
            lres_sat = lres[23:0];
        end
    end

    mlcd_div #(.NW(DIV_NW), .DW(SUMW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ram_raddr  = coef_addr;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode)
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (first_reg)
                begin
                    ram_raddr  = AW'(slot_reg);
                    state_next = S_IWT;
                end
                else
                begin
                    state_next = apply_reg ? S_CRD : S_NXT;
                end
            end
            S_IWT:   state_next = apply_reg ? S_CRD : S_NXT;
            S_CRD:   state_next = S_CWT;
            S_CWT:   state_next = S_ADD;
            S_ADD:   state_next = S_NXT;
            S_NXT:   state_next = (int'(slot_reg) == NSLOT - 1) ? S_FIN : S_SLOT;
            S_FIN:   state_next = (!last_reg || bad_obs) ? S_IDLE : S_MAX;
            S_MAX:   state_next = (k_reg < keff_reg) ? S_MAX : S_E0;
            S_E0:    state_next = (k_reg == keff_reg) ? S_RES : S_E1;
            S_E1:    state_next = S_E2;
            S_E2:    state_next = S_E3;
            S_E3:    state_next = S_E4;
            S_E4:    state_next = S_E0;
            S_RES:   state_next = S_DGO;
            S_DGO:
            begin
                div_start  = 1'b1;
                state_next = S_DWT;
            end
            S_DWT:
            begin
                if (div_stat.done)
                begin
                    state_next = log_reg ? S_L1 : S_IDLE;
                end
            end
            S_L1:    state_next = S_L2;
            S_L2:    state_next = S_L3;
            S_L3:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg   <= 4'd2;
            cc_reg   <= 4'd2;
            log_reg  <= 1'b0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_FEATURE_COUNT:  fc_reg  <= pwdata[3:0];
                    REG_CATEGORY_COUNT: cc_reg  <= pwdata[3:0];
                    REG_LOG_OUTPUT:     log_reg <= pwdata[0];
                    default:            ;
                endcase
            end
            if (state_reg == S_FIN)
            begin
                if (!last_reg)
                begin
                    if (pos_reg != 4'd15)
                    begin
                        pos_reg <= pos_reg + 4'd1;
                    end
                end
                else
                begin
                    pos_reg <= '0;
                    if (bad_obs)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
            if ((state_reg == S_DWT && div_stat.done && !log_reg) || state_reg == S_L3)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode)
                begin
                    val_reg   <= value;
                    obs_reg   <= observed_category;
                    last_reg  <= last_feature;
                    first_reg <= (pos_reg == 4'd0);
                    apply_reg <= (pos_reg < fc_reg) && (int'(pos_reg) + 1 < MAX_TERMS);
                    slot_reg  <= '0;
                    keff_reg  <= (int'(cc_reg) >= MAX_CATEGORIES) ? KW'(MAX_CATEGORIES)
                                                                  : KW'(cc_reg);
                end
            end
            S_IWT:   lp_reg[slot_reg] <= {{(LP_W-VAL_W){ram_rdata[VAL_W-1]}}, ram_rdata};
            S_CWT:   prod_reg <= val_reg * $signed(ram_rdata);
            S_ADD:   lp_reg[slot_reg] <= acc_sat;
            S_NXT:   slot_reg <= slot_reg + IW'(1);
            S_FIN:
            begin
                k_reg <= KW'(1);
                m_reg <= '0;
                if (bad_obs)
                begin
                    density_reg <= '0;
                    cat_err_reg <= 1'b1;
                end
            end
            S_MAX:
            begin
                if (k_reg < keff_reg)
                begin
                    if (lp_rd > m_reg)
                    begin
                        m_reg <= lp_rd;
                    end
                    k_reg <= k_reg + KW'(1);
                end
                else
                begin
                    k_reg   <= '0;
                    sum_reg <= '0;
                end
            end
            S_E0:
            begin
                n_reg    <= {m_reg[LP_W-1], m_reg} - {eta[LP_W-1], eta};
                deta_reg <= {eta[LP_W-1], eta} - {m_reg[LP_W-1], m_reg};
            end
            S_E1:
            begin
                zero_reg <= (n_reg[LP_W:16] >= (LP_W-15)'(12));
                r_reg    <= n_reg[12:0];
                r2_reg   <= 10'(({13'd0, n_reg[12:0]} * {13'd0, n_reg[12:0]}) >> 16);
                eif_reg  <= {16'd0, exp_int_lut(n_reg[19:16])} *
                            {16'd0, exp_frac_lut(n_reg[15:13])};
            end
            S_E2:
            begin
                r3_reg <= 7'(({13'd0, r2_reg} * {10'd0, r_reg}) >> 16);
                e1_reg <= 17'((eif_reg + 33'd32768) >> 16);
            end
            S_E3:
            begin
                poly_reg <= 17'(Q_ONE) - {4'd0, r_reg} + {8'd0, r2_reg[9:1]}
                          - 17'(({17'd0, r3_reg} * 24'd43691) >> 18);
            end
            S_E4:
            begin
                sum_reg <= sum_reg + SUMW'(e_cur);
                if (int'(k_reg) == int'(obs_m1))
                begin
                    e_obs_reg <= e_cur;
                    d_obs_reg <= deta_reg;
                end
                k_reg <= k_reg + KW'(1);
            end
            S_RES:
            begin
                ks_reg <= ks;
                j_reg  <= 3'(sum_reg >> (ks + KSW'(13)));
                if (log_reg)
                begin
                    div_num_reg <= DIV_NW'({13'(sum_reg >> ks), 16'd0});
                    div_den_reg <= SUMW'({1'b1, 3'(sum_reg >> (ks + KSW'(13))), 13'd0});
                end
                else
                begin
                    div_num_reg <= DIV_NW'({e_obs_reg, 16'd0}) + DIV_NW'(sum_reg >> 1);
                    div_den_reg <= sum_reg;
                end
            end
            S_DWT:
            begin
                if (div_stat.done && !log_reg)
                begin
                    density_reg <= div_quot[23:0];
                    cat_err_reg <= 1'b0;
                end
                t_reg <= div_quot[12:0];
            end
            S_L1:    t2_reg <= 10'(({13'd0, t_reg} * {13'd0, t_reg}) >> 16);
            S_L2:    t3_reg <= 7'(({13'd0, t2_reg} * {10'd0, t_reg}) >> 16);
            S_L3:
            begin
                density_reg <= lres_sat;
                cat_err_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    assign done           = done_reg;
    assign density        = density_reg;
    assign category_error = cat_err_reg;
endmodule
`default_nettype wire

[hdl/mlcd_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module mlcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 112
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/mlcd_div.sv]
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module mlcd_div import mlcd_pkg::*; #(
    parameter int NW = 34,
    parameter int DW = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] quot,
    output div_stat_t          stat
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quot_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;

    assign rem_sh  = {rem_reg, quot_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= den;
            quot_reg <= num;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[DW])
            begin
                rem_reg  <= rem_sub[DW-1:0];
                quot_reg <= {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[DW-1:0];
                quot_reg <= {quot_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

[tb/multinomial_logit_category_density_test.sv]
// self-checking testbench for the multinomial logit category density block
`default_nettype none
module multinomial_logit_category_density_test;
    import mlcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT        = DEF_MAX_CATEGORIES - 1;
    localparam int WATCH_LIMIT  = 20000;
    localparam int SETTLE_CYC   = 200;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_COVAR = 1'b1;
    localparam longint LP_HI    = 64'sd549755813887;
    localparam longint LP_LO    = -64'sd549755813888;

    typedef struct {
        logic        mode;
        logic [3:0]  term;
        logic [2:0]  slot;
        logic [23:0] val;
        logic [3:0]  obs;
        logic        last;
        logic        has_fixed;   // expected result typed into the table
        logic [23:0] fixed_density;
        logic        fixed_err;
    } beat_t;

    typedef struct {
        logic [23:0] density;
        logic        err;
    } result_t;

    logic clk = 1'b0, rst_n = 1'b0;
    logic start = 1'b0, mode = 1'b0, last_feature = 1'b0;
    logic [3:0] term_index = '0, observed_category = '0;
    logic [2:0] category_slot = '0;
    logic signed [23:0] value = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic busy, done, category_error, pready;
    wire logic signed [23:0] density;
    wire logic [31:0] prdata;

    multinomial_logit_category_density u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    longint coef_q[DEF_MAX_TERMS*NSLOT];
    bit     coef_written[DEF_MAX_TERMS*NSLOT];
    longint eta_acc[NSLOT];
    int     feat_pos;
    int     n_features = 2, n_categories = 2;
    bit     log_mode = 1'b0;

    result_t density_expected[$];
    int errors = 0, watch = 0, results_seen = 0, beats_sent = 0;

    function automatic longint floor16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint sat40(longint x);
        if (x > LP_HI) return LP_HI;
        if (x < LP_LO) return LP_LO;
        return x;
    endfunction

    function automatic longint exp_neg_q16(longint n);
        longint i, j, r, r2, r3, poly, e;
        i = n >>> 16;
        if (i >= 12) return 0;
        j = (n >>> 13) & 7;
        r = n & 64'h1FFF;
        r2 = (r * r) >>> 16;
        r3 = (r2 * r) >>> 16;
        poly = 65536 - r + (r2 >>> 1) - r3 / 6;
        e = (longint'(exp_int_lut(i[3:0])) * longint'(exp_frac_lut(j[2:0])) + 32768) >>> 16;
        return (e * poly + 32768) >>> 16;
    endfunction

    function automatic longint ln_sum_q16(longint s);
        longint k, mant, j, base, t, t2, t3;
        k = 0;
        mant = s;
        while (mant >= 2 * 65536)
        begin
            mant = mant >>> 1;
            k++;
        end
        j = (mant >>> 13) & 7;
        base = 65536 + j * 8192;
        t = ((mant - base) <<< 16) / base;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        return k * LN2_Q16 + longint'(ln_lut(j[2:0])) + t - (t2 >>> 1) + t3 / 3;
    endfunction

    // advances the predictor by one beat, returns 1 when a result is due
    function automatic bit predict_density(beat_t b, output result_t res);
        longint v, m, eta, e, e_obs, d_obs, sum, r;
        int keff, row;
        v = longint'(signed'(b.val));
        res.density = '0;
        res.err = 1'b0;
        if (b.mode == MODE_LOAD)
        begin
            if (b.slot < NSLOT)
            begin
                coef_q[b.term*NSLOT + b.slot] = v;
                coef_written[b.term*NSLOT + b.slot] = 1'b1;
            end
            return 1'b0;
        end
        if (feat_pos == 0)
            for (int s = 0; s < NSLOT; s++) eta_acc[s] = coef_q[s];
        row = feat_pos + 1;
        if (feat_pos < n_features && row < DEF_MAX_TERMS)
            for (int s = 0; s < NSLOT; s++)
                eta_acc[s] = sat40(eta_acc[s] + floor16(v * coef_q[row*NSLOT + s]));
        if (!b.last)
        begin
            if (feat_pos < 15) feat_pos++;
            return 1'b0;
        end
        feat_pos = 0;
        keff = n_categories < DEF_MAX_CATEGORIES ? n_categories : DEF_MAX_CATEGORIES;
        if (b.obs == 0 || b.obs > keff)
        begin
            res.err = 1'b1;
            return 1'b1;
        end
        m = 0;
        for (int k = 1; k < keff; k++) if (eta_acc[k-1] > m) m = eta_acc[k-1];
        sum = 0;
        e_obs = 0;
        d_obs = 0;
        for (int k = 0; k < keff; k++)
        begin
            eta = k ? eta_acc[k-1] : 0;
            e = exp_neg_q16(m - eta);
            sum += e;
            if (k == b.obs - 1)
            begin
                e_obs = e;
                d_obs = eta - m;
            end
        end
        if (log_mode)
        begin
            r = d_obs - ln_sum_q16(sum);
            if (r < -8388608) r = -8388608;
            if (r > 8388607) r = 8388607;
        end
        else
        begin
            r = (e_obs * 65536 + sum / 2) / sum;
        end
        res.density = r[23:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (density_expected.size() == 0)
            begin
                report_mismatch("unexpected result beat", density, 0);
            end
            else
            begin
                result_t want;
                want = density_expected.pop_front();
                if (density !== want.density)
                    report_mismatch("density", density, signed'(want.density));
                if (category_error !== want.err)
                    report_mismatch("category_error", category_error, want.err);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || psel) watch <= 0;
        else watch <= watch + 1;
        if (watch >= WATCH_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", density_expected.size());
            $display("multinomial_logit_category_density verification failed");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FEATURE_COUNT:  n_features = int'(data[3:0]);
            REG_CATEGORY_COUNT: n_categories = int'(data[3:0]);
            REG_LOG_OUTPUT:     log_mode = data[0];
            default: ;
        endcase
    endtask

    // drives one beat; predictor runs at the accepting edge
    // start stays high into the next beat unless a gap is drawn
    task automatic send_beat(beat_t b, bit allow_gap);
        result_t res;
        if (allow_gap)
            while ($urandom_range(99) < 15)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        mode <= b.mode; term_index <= b.term; category_slot <= b.slot;
        value <= b.val; observed_category <= b.obs; last_feature <= b.last;
        do @(posedge clk); while (busy);
        beats_sent++;
        if (predict_density(b, res))
        begin
            if (b.has_fixed)
            begin
                res.density = b.fixed_density;
                res.err = b.fixed_err;
            end
            density_expected.push_back(res);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (density_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic beat_t mk(logic md, int term, int slot, int val, int obs, bit lst);
        beat_t b;
        b.mode = md; b.term = 4'(term); b.slot = 3'(slot); b.val = 24'(val);
        b.obs = 4'(obs); b.last = lst; b.has_fixed = 1'b0;
        b.fixed_density = '0; b.fixed_err = 1'b0;
        return b;
    endfunction

    function automatic beat_t mk_fixed(beat_t b, int d, bit e);
        b.has_fixed = 1'b1; b.fixed_density = 24'(d); b.fixed_err = e;
        return b;
    endfunction

    task automatic load_all_coefs(int mag);
        for (int t = 0; t < DEF_MAX_TERMS; t++)
            for (int s = 0; s < NSLOT; s++)
                send_beat(mk(MODE_LOAD, t, s, $urandom_range(2*mag) - mag, 0, 0), 1'b1);
    endtask

    task automatic random_observation(int mag, int n_cov);
        beat_t b;
        for (int i = 0; i < n_cov; i++)
        begin
            b = mk(MODE_COVAR, $urandom_range(15), $urandom_range(7),
                   $urandom_range(2*mag) - mag, $urandom_range(15), i == n_cov - 1);
            if ($urandom_range(9) == 0) b.val = 24'($urandom);
            if (b.last && $urandom_range(3) != 0)
                b.obs = 4'($urandom_range(n_categories > 8 ? 8 : n_categories, 1));
            send_beat(b, 1'b1);
        end
    endtask

    beat_t directed_rows[$];

    initial
    begin
        for (int i = 0; i < DEF_MAX_TERMS*NSLOT; i++)
        begin
            coef_q[i] = 0;
            coef_written[i] = 1'b0;
        end
        for (int s = 0; s < NSLOT; s++) eta_acc[s] = 0;
        feat_pos = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every store entry gets written first so no unwritten read occurs
        for (int t = 0; t < DEF_MAX_TERMS; t++)
            for (int s = 0; s < NSLOT; s++)
                send_beat(mk(MODE_LOAD, t, s, 0, 0, 0), 1'b0);
        // zero coefficients, two categories: probability one half
        directed_rows.push_back(mk(MODE_COVAR, 0, 0, 24'h7FFFFF, 0, 0));
        directed_rows.push_back(mk_fixed(mk(MODE_COVAR, 0, 0, 24'h800000, 1, 1), 32768, 0));
        // observed category zero and above count
        directed_rows.push_back(mk_fixed(mk(MODE_COVAR, 0, 0, 1, 0, 1), 0, 1));
        directed_rows.push_back(mk_fixed(mk(MODE_COVAR, 0, 0, 1, 15, 1), 0, 1));
        directed_rows.push_back(mk_fixed(mk(MODE_COVAR, 0, 0, 1, 3, 1), 0, 1));
        // extreme coefficient loads, ignored slot 7
        directed_rows.push_back(mk(MODE_LOAD, 0, 0, 24'h7FFFFF, 0, 0));
        directed_rows.push_back(mk(MODE_LOAD, 1, 0, 24'h800000, 0, 0));
        directed_rows.push_back(mk(MODE_LOAD, 15, 6, 24'h7FFFFF, 0, 0));
        directed_rows.push_back(mk(MODE_LOAD, 15, 7, 24'h123456, 0, 0));
        directed_rows.push_back(mk(MODE_COVAR, 0, 0, 24'h7FFFFF, 0, 0));
        directed_rows.push_back(mk(MODE_COVAR, 0, 0, 24'h800000, 2, 1));
        // too few covariates then too many
        directed_rows.push_back(mk(MODE_COVAR, 0, 0, 24'h010000, 1, 1));
        for (int i = 0; i < 5; i++)
            directed_rows.push_back(mk(MODE_COVAR, 15, 7, 24'h008000, 2, i == 4));
        foreach (directed_rows[i]) send_beat(directed_rows[i], 1'b0);
        wait_idle();

        // settings sweep, extremes included; random part after
        for (int phase = 0; phase < 6; phase++)
        begin
            int fc, cc, mag;
            fc = phase == 0 ? 1 : phase == 1 ? 15 : $urandom_range(15, 1);
            cc = phase == 0 ? 2 : phase == 1 ? 8 : phase == 2 ? 15 : $urandom_range(8, 2);
            // registers change only with nothing in flight
            wait_idle();
            reg_write(REG_FEATURE_COUNT, fc);
            reg_write(REG_CATEGORY_COUNT, cc);
            reg_write(REG_LOG_OUTPUT, phase % 2);
            mag = phase < 2 ? 8388607 : (phase % 3 == 0 ? 65536 : 1 << $urandom_range(20, 12));
            load_all_coefs(mag);
            for (int o = 0; o < 6; o++)
            begin
                if (o < 2) random_observation(mag, n_features);
                else random_observation(mag, $urandom_range(n_features + 2, 1));
            end
        end
        // long stretch with no gaps, back-to-back beats
        for (int i = 0; i < 60; i++)
            send_beat(mk(MODE_COVAR, 0, 0, $urandom, $urandom_range(8, 1),
                         $urandom_range(2) == 0), 1'b0);
        send_beat(mk(MODE_COVAR, 0, 0, 0, 1, 1), 1'b0);
        wait_idle();

        $display("sent %0d beats, checked %0d results", beats_sent, results_seen);
        $display("covered loads, covariate streams, log and linear output, bad categories");
        if (errors == 0)
            $display("multinomial_logit_category_density verification clean");
        else
            $display("multinomial_logit_category_density verification failed");
        $finish;
    end
endmodule
`default_nettype wire
